[src/gdd_pkg.sv]
`default_nettype none
package gdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;
  localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;

  // inverse of 25 modulo 2^14; y*INV25 lands at or below the limit only when 25 divides y
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } gdd_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic emit;
  } gdd_cmd_t;

  typedef struct packed {
    logic dates_ok;
    logic start_before;
    logic at_end;
    logic out_free;
  } gdd_sts_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic div4;
    logic div16;
    logic div25;
    prod  = y * INV25;
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
    return div4 && (!div25 || div16);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[src/gdd_ctrl.sv]
`default_nettype none
module gdd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire gdd_pkg::gdd_sts_t sts,
  output gdd_pkg::gdd_cmd_t      cmd
);
  import gdd_pkg::*;

  gdd_state_t state_r;
  gdd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.init = 1'b1;
        if (sts.dates_ok && sts.start_before) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WALK: begin
        if (sts.at_end) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        // wait until the output register can take the result
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/gdd_dp.sv]
`default_nettype none
module gdd_dp #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [gdd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire gdd_pkg::gdd_cmd_t                  cmd,
  output gdd_pkg::gdd_sts_t                       sts,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gdd_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import gdd_pkg::*;

  localparam logic [YEAR_W-1:0] YEAR_LIM = YEAR_W'(MAX_YEAR);

  logic [DAY_W-1:0]   sd_r, ed_r, wd_r, wd_nxt;
  logic [MONTH_W-1:0] sm_r, em_r, wm_r, wm_nxt;
  logic [YEAR_W-1:0]  sy_r, ey_r, wy_r, wy_nxt;
  logic               inc_r;
  logic               invalid_r;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_invalid_r;

  logic               start_ok, end_ok;
  logic [DAY_W-1:0]   walk_len;
  logic [COUNT_W:0]   final_sum;
  logic [COUNT_W-1:0] final_count;

  // capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sd_r  <= in_tdata[4:0];
      sm_r  <= in_tdata[8:5];
      sy_r  <= in_tdata[22:9];
      ed_r  <= in_tdata[27:23];
      em_r  <= in_tdata[31:28];
      ey_r  <= in_tdata[45:32];
      inc_r <= in_tdata[46];
    end
  end

  assign start_ok = (sy_r <= YEAR_LIM) && (sd_r != '0) &&
                    (sd_r <= month_len(sm_r, is_leap(sy_r)));
  assign end_ok   = (ey_r <= YEAR_LIM) && (ed_r != '0) &&
                    (ed_r <= month_len(em_r, is_leap(ey_r)));

  // one day forward from the walk date
  assign walk_len = month_len(wm_r, is_leap(wy_r));

  always_comb begin
    wd_nxt = wd_r + 5'd1;
    wm_nxt = wm_r;
    wy_nxt = wy_r;
    if (wd_r == walk_len) begin
      wd_nxt = 5'd1;
      if (wm_r == DECEMBER) begin
        wm_nxt = JANUARY;
        wy_nxt = wy_r + 14'd1;
      end else begin
        wm_nxt = wm_r + 4'd1;
      end
    end
    cnt_nxt = (cnt_r == COUNT_MAX) ? COUNT_MAX : cnt_r + 22'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      wd_r      <= sd_r;
      wm_r      <= sm_r;
      wy_r      <= sy_r;
      cnt_r     <= '0;
      invalid_r <= !(start_ok && end_ok);
    end else if (cmd.step) begin
      wd_r  <= wd_nxt;
      wm_r  <= wm_nxt;
      wy_r  <= wy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign final_sum   = {1'b0, cnt_r} + {{COUNT_W{1'b0}}, inc_r};
  assign final_count = final_sum[COUNT_W] ? COUNT_MAX : final_sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r   <= invalid_r ? '0 : final_count;
      out_invalid_r <= invalid_r;
    end
  end

  assign sts.dates_ok     = start_ok && end_ok;
  assign sts.start_before = {sy_r, sm_r, sd_r} < {ey_r, em_r, ed_r};
  assign sts.at_end       = (wd_r == ed_r) && (wm_r == em_r) && (wy_r == ey_r);
  assign sts.out_free     = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_invalid_r, out_count_r};

endmodule
`default_nettype wire

[src/gregorian_date_difference.sv]
// channel  dir  tdata fields, lowest bit up
// in_      in   start_day[4:0] start_month[8:5] start_year[22:9] end_day[27:23]
//               end_month[31:28] end_year[45:32] count_end_day[46], zero [47]
// out_     out  day_count[21:0] date_invalid[22], zero [23]
//
// the walk steps one day per cycle through the date counter, so the span of days
// between the dates sets how long an item takes.
// an invalid date, or a start not before the end, skips the walk.
// one item is in work at a time; the next is taken once the result sits in the
// output register, which holds it while out_tready is low.
// rst_n is synchronous, active low, and empties the block.
`default_nettype none
module gregorian_date_difference #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, count_end_day
  input  wire logic [gdd_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // day_count, date_invalid
  output logic [gdd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import gdd_pkg::*;

  gdd_cmd_t cmd;
  gdd_sts_t sts;

  gdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdd_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[src/gdd_checker.sv]
`default_nettype none
module gdd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [gdd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // an invalid date never carries a count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tdata[21:0] == 22'd0)
    else $error("invalid date with nonzero count");

  // one item at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[tb/tb_top.sv]
module tb_top;

  localparam int MAX_YEAR     = 9999;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 77;
  // keeps random walks short, the long spans are directed
  localparam int SHORT_SPAN   = 4000;
  localparam int CORNER_YEARS [8] = '{0, 1, 100, 400, 1900, 2000, 9996, 9999};

  typedef struct {
    logic [gdd_pkg::DAY_W-1:0]   sd;
    logic [gdd_pkg::MONTH_W-1:0] sm;
    logic [gdd_pkg::YEAR_W-1:0]  sy;
    logic [gdd_pkg::DAY_W-1:0]   ed;
    logic [gdd_pkg::MONTH_W-1:0] em;
    logic [gdd_pkg::YEAR_W-1:0]  ey;
    logic                        inc;
  } date_pair_t;

  typedef struct {
    logic [gdd_pkg::COUNT_W-1:0] count;
    logic                        invalid;
  } span_result_t;

  class span_scoreboard;
    span_result_t pending[$];
    int unsigned  mismatches;
    int unsigned  items;
    int unsigned  flagged;
    int unsigned  widest;

    static function bit is_leap_year(int y);
      return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    static function int days_in_month(int m, int y);
      case (m)
        2: begin
          return is_leap_year(y) ? 29 : 28;
        end
        4, 6, 9, 11: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    static function bit calendar_ok(int d, int m, int y);
      if (m < 1 || m > 12 || y > MAX_YEAR) begin
        return 1'b0;
      end
      return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // days since 0-01-01, year 0 counted as leap
    static function int day_index(int d, int m, int y);
      int n;
      n = 365 * y;
      if (y > 0) begin
        n += (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      end
      for (int mo = 1; mo < m; mo++) begin
        n += days_in_month(mo, y);
      end
      return n + d - 1;
    endfunction

    static function span_result_t predict_span(date_pair_t p);
      span_result_t r;
      int a;
      int b;
      int c;
      r.count   = '0;
      r.invalid = 1'b0;
      if (!calendar_ok(p.sd, p.sm, p.sy) || !calendar_ok(p.ed, p.em, p.ey)) begin
        r.invalid = 1'b1;
        return r;
      end
      a = day_index(p.sd, p.sm, p.sy);
      b = day_index(p.ed, p.em, p.ey);
      c = (a < b) ? b - a : 0;
      c += p.inc;
      if (c > int'(gdd_pkg::COUNT_MAX)) begin
        c = int'(gdd_pkg::COUNT_MAX);
      end
      r.count = 22'(c);
      return r;
    endfunction

    function void note_dates(input logic [gdd_pkg::IN_TDATA_W-1:0] t);
      date_pair_t   p;
      span_result_t r;
      p.sd  = t[4:0];
      p.sm  = t[8:5];
      p.sy  = t[22:9];
      p.ed  = t[27:23];
      p.em  = t[31:28];
      p.ey  = t[45:32];
      p.inc = t[46];
      r = predict_span(p);
      items++;
      if (r.invalid) begin
        flagged++;
      end
      if (r.count > widest) begin
        widest = r.count;
      end
      pending.push_back(r);
    endfunction

    function void check_result(input logic [gdd_pkg::OUT_TDATA_W-1:0] t);
      span_result_t w;
      if (pending.size() == 0) begin
        $error("result with no item pending: day_count %0d date_invalid %0b", t[21:0], t[22]);
        mismatches++;
        return;
      end
      w = pending.pop_front();
      if (t[21:0] !== w.count) begin
        $error("day_count expected %0d actual %0d", w.count, t[21:0]);
        mismatches++;
      end
      if (t[22] !== w.invalid) begin
        $error("date_invalid expected %0b actual %0b", w.invalid, t[22]);
        mismatches++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [gdd_pkg::IN_TDATA_W-1:0]    in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [gdd_pkg::OUT_TDATA_W-1:0]   out_tdata;

  span_scoreboard sb = new();
  bit             steady = 1'b0;
  int unsigned    sent = 0;
  int unsigned    cycles = 0;

  gregorian_date_difference u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_dates(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, sb.pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [gdd_pkg::IN_TDATA_W-1:0] pack_dates(date_pair_t p);
    return {1'b0, p.inc, p.ey, p.em, p.ed, p.sy, p.sm, p.sd};
  endfunction

  function automatic date_pair_t mk(int sd, int sm, int sy, int ed, int em, int ey, int inc);
    date_pair_t p;
    p.sd  = 5'(sd);
    p.sm  = 4'(sm);
    p.sy  = 14'(sy);
    p.ed  = 5'(ed);
    p.em  = 4'(em);
    p.ey  = 14'(ey);
    p.inc = 1'(inc);
    return p;
  endfunction

  function automatic date_pair_t swap_dates(date_pair_t p);
    return mk(p.ed, p.em, p.ey, p.sd, p.sm, p.sy, p.inc);
  endfunction

  // valid dates a few years apart at most, often across a year boundary
  function automatic date_pair_t random_pair();
    date_pair_t p;
    int y0;
    int y1;
    int m0;
    int m1;
    y0 = ($urandom_range(0, 3) == 0) ? CORNER_YEARS[$urandom_range(0, 7)]
                                     : $urandom_range(0, MAX_YEAR);
    y1 = y0 + $urandom_range(0, 2);
    if (y1 > MAX_YEAR) begin
      y1 = MAX_YEAR;
    end
    m0 = $urandom_range(1, 12);
    m1 = $urandom_range(1, 12);
    p = mk($urandom_range(1, span_scoreboard::days_in_month(m0, y0)), m0, y0,
           $urandom_range(1, span_scoreboard::days_in_month(m1, y1)), m1, y1,
           $urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) begin
      p = swap_dates(p);
    end else if ($urandom_range(0, 15) == 0) begin
      p = mk(p.sd, p.sm, p.sy, p.sd, p.sm, p.sy, p.inc);
    end
    return p;
  endfunction

  // raw field values, mostly bad dates
  function automatic date_pair_t noise_pair();
    date_pair_t   p;
    span_result_t r;
    p = mk($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383),
           $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383),
           $urandom_range(0, 1));
    r = span_scoreboard::predict_span(p);
    if (!r.invalid && r.count > SHORT_SPAN) begin
      p = swap_dates(p);
    end
    return p;
  endfunction

  task automatic send_dates(input date_pair_t p);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_dates(p);
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_dates(mk(28, 2, 2000, 1, 3, 2000, 0));
    send_dates(mk(28, 2, 1900, 1, 3, 1900, 0));
    send_dates(mk(29, 2, 2024, 1, 3, 2024, 1));
    send_dates(mk(29, 2, 2023, 1, 3, 2023, 0));
    send_dates(mk(1, 1, 0, 31, 12, 0, 1));
    send_dates(mk(29, 2, 0, 1, 3, 0, 0));
    send_dates(mk(31, 12, 9999, 31, 12, 9999, 0));
    send_dates(mk(31, 12, 9999, 31, 12, 9999, 1));
    send_dates(mk(31, 12, 9999, 1, 1, 0, 1));
    send_dates(mk(31, 12, 1999, 1, 1, 2000, 0));
    send_dates(mk(30, 4, 2021, 1, 5, 2021, 1));
    // bad months, then bad days
    send_dates(mk(1, 0, 2020, 1, 1, 2021, 0));
    send_dates(mk(1, 1, 2020, 1, 13, 2020, 1));
    send_dates(mk(15, 15, 2020, 20, 7, 2020, 0));
    send_dates(mk(0, 6, 2020, 1, 7, 2020, 0));
    send_dates(mk(31, 4, 2020, 1, 5, 2020, 0));
    send_dates(mk(29, 2, 2100, 1, 3, 2100, 1));
    // years past the limit, then valid spans and a start after its end
    send_dates(mk(1, 1, 10000, 1, 1, 2020, 0));
    send_dates(mk(1, 1, 2020, 1, 1, 16383, 1));
    send_dates(mk(31, 1, 8191, 1, 2, 8192, 0));
    send_dates(mk(31, 12, 0, 1, 1, 1, 0));
    send_dates(mk(1, 3, 2100, 28, 2, 2100, 0));
    // one long walk across a thousand years
    send_dates(mk(1, 3, 1000, 29, 2, 2000, 1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 70);
      send_dates(($urandom_range(0, 99) < 80) ? random_pair() : noise_pair());
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.items != sent || sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    $display("checked %0d date pairs, %0d with an invalid date, widest count %0d days",
             sb.items, sb.flagged, sb.widest);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
